[rtl/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the partition fit allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // Default sizing of the partition table.
    localparam int NUM_BLOCKS_DEF = 8;
    localparam int SIZE_BITS_DEF  = 16;

    // Configuration port sizing.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_POLICY = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COUNT  = 1'd1;

    // Reset value of the partition count register.
    localparam logic [3:0] COUNT_RESET = 4'd8;

    // Item modes.
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    // Placement policies.
    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_NEXT  = 2'd3
    } t_policy;

    // Input word.
    typedef struct packed {
        logic        mode;
        logic [2:0]  block_index;
        logic [15:0] size_value;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic        granted;
        logic [2:0]  block_number;
        logic [15:0] remaining;
    } t_out_word;

    // Control from the scan sequencer to the candidate tracker.
    typedef struct packed {
        logic clear;  // start of a new search
        logic valid;  // an entry read from the table is presented
    } t_pick_ctl;

endpackage

[rtl/partition_fit_allocator.sv]
// ----------------------------------------------------------------------------
// partition_fit_allocator
// Partition table with first, best, worst and next fit placement.
// ----------------------------------------------------------------------------
// Usage: an input word is taken at a clock edge with i_start high and o_busy
// low. A load word (mode 0) writes one partition's free size and rewinds the
// next-fit pointer; its result appears with o_done in the next cycle and the
// block stays ready. A request word (mode 1) scans the first block_count
// partitions through the table memory, one read per cycle, then writes the
// chosen entry back. o_busy stays high through the scan and the write-back,
// and o_done shows the result in the first cycle with o_busy low again. The
// scan reads the table through its single read port. Each result is flagged
// by o_done for exactly one cycle and holds on o_res until the next result;
// the receiver cannot stall it. Configuration registers are written through
// i_cfg_we / i_cfg_addr / i_cfg_wdata; the user must write them only while
// the block is idle, which the block itself does not enforce. Reset rewinds
// the next-fit pointer and restores the register defaults; table entries
// hold nothing defined until loaded.
// ----------------------------------------------------------------------------
module partition_fit_allocator
    import pfa_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_in_word              i_req,
    output logic                  o_busy,
    output logic                  o_done,
    output t_out_word             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // Partition table.
    logic [SIZE_BITS-1:0] mem_free [NUM_BLOCKS];

    // Registers.
    t_state               r_state, n_state;
    t_policy              r_policy;
    logic [3:0]           r_cfg_count;
    logic [3:0]           r_count, n_count;
    logic [3:0]           r_left, n_left;
    logic [IDX_W-1:0]     r_addr, n_addr;
    logic                 r_rv, n_rv;
    logic [IDX_W-1:0]     r_ridx, n_ridx;
    logic [SIZE_BITS-1:0] r_rdata;
    logic [SIZE_BITS-1:0] r_size, n_size;
    logic [IDX_W-1:0]     r_ptr, n_ptr;
    logic                 r_done, n_done;
    t_out_word            r_res, n_res;

    // Datapath signals.
    logic                 w_accept;
    logic [3:0]           w_count;
    logic [SIZE_BITS-1:0] w_in_size;
    logic [IDX_W-1:0]     w_load_idx;
    logic                 w_load_ok;
    logic                 w_rd_en;
    logic                 w_wr_en;
    logic [IDX_W-1:0]     w_wr_addr;
    logic [SIZE_BITS-1:0] w_wr_data;
    logic [SIZE_BITS-1:0] w_new_size;
    t_pick_ctl            w_pick_ctl;
    logic                 w_found;
    logic [IDX_W-1:0]     w_pick_idx;
    logic [SIZE_BITS-1:0] w_pick_val;

    // Input decode.
    always_comb begin
        w_accept   = i_start && (r_state == ST_IDLE);
        w_count    = (int'(r_cfg_count) > NUM_BLOCKS) ? 4'(NUM_BLOCKS) : r_cfg_count;
        w_in_size  = SIZE_BITS'(i_req.size_value);
        w_load_idx = IDX_W'(i_req.block_index);
        w_load_ok  = int'(i_req.block_index) < NUM_BLOCKS;
        w_new_size = w_pick_val - r_size;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= FIT_FIRST;
            r_cfg_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_POLICY: r_policy    <= t_policy'(i_cfg_wdata[1:0]);
                CFG_COUNT:  r_cfg_count <= i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    // Sequencer: accept, scan the table one entry per cycle, write back.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_left  = r_left;
        n_addr  = r_addr;
        n_rv    = 1'b0;
        n_ridx  = r_ridx;
        n_size  = r_size;
        n_ptr   = r_ptr;
        n_done  = 1'b0;
        n_res   = r_res;
        w_rd_en    = 1'b0;
        w_wr_en    = 1'b0;
        w_wr_addr  = w_pick_idx;
        w_wr_data  = w_new_size;
        w_pick_ctl = '{clear: 1'b0, valid: r_rv};

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req.mode == MODE_LOAD) begin
                        // Load: write the entry and report it right away.
                        n_ptr     = '0;
                        w_wr_en   = w_load_ok;
                        w_wr_addr = w_load_idx;
                        w_wr_data = w_in_size;
                        n_done    = 1'b1;
                        n_res.granted      = 1'b0;
                        n_res.block_number = i_req.block_index;
                        n_res.remaining    = w_load_ok ? 16'(w_in_size) : 16'd0;
                    end else begin
                        // Request: set up the scan.
                        w_pick_ctl.clear = 1'b1;
                        n_size  = w_in_size;
                        n_count = w_count;
                        n_left  = w_count;
                        n_addr  = (r_policy == FIT_NEXT && int'(r_ptr) < int'(w_count)) ?
                                  r_ptr : '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_left != 4'd0) begin
                    // Issue one table read; the data returns next cycle.
                    w_rd_en = 1'b1;
                    n_rv    = 1'b1;
                    n_ridx  = r_addr;
                    n_left  = r_left - 4'd1;
                    n_addr  = (int'(r_addr) + 1 >= int'(r_count)) ? '0 : r_addr + 1'b1;
                end else begin
                    // The last read is taken by the tracker at this edge.
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // Write back the chosen entry and present the result.
                w_wr_en = w_found;
                n_done  = 1'b1;
                n_state = ST_IDLE;
                if (w_found) begin
                    n_res.granted      = 1'b1;
                    n_res.block_number = 3'(w_pick_idx);
                    n_res.remaining    = 16'(w_new_size);
                    if (r_policy == FIT_NEXT) begin
                        n_ptr = w_pick_idx;
                    end
                end else begin
                    n_res = '0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_left  <= 4'd0;
            r_rv    <= 1'b0;
            r_ptr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_rv    <= n_rv;
            r_ptr   <= n_ptr;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= n_count;
        r_addr  <= n_addr;
        r_ridx  <= n_ridx;
        r_size  <= n_size;
        r_res   <= n_res;
    end

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_free[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= mem_free[r_addr];
        end
    end

    // Candidate tracker.
    pfa_pick #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W)
    ) u_pick (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_pick_ctl),
        .i_policy (r_policy),
        .i_idx    (r_ridx),
        .i_val    (r_rdata),
        .i_size   (r_size),
        .o_found  (w_found),
        .o_idx    (w_pick_idx),
        .o_val    (w_pick_val)
    );

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[rtl/pfa_pick.sv]
// ----------------------------------------------------------------------------
// pfa_pick
// Candidate tracker: keeps the partition chosen so far while table entries
// stream past in scan order, applying the placement policy.
// ----------------------------------------------------------------------------
module pfa_pick
    import pfa_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    parameter int IDX_W     = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_pick_ctl            i_ctl,
    input  t_policy              i_policy,
    input  logic [IDX_W-1:0]     i_idx,
    input  logic [SIZE_BITS-1:0] i_val,
    input  logic [SIZE_BITS-1:0] i_size,
    output logic                 o_found,
    output logic [IDX_W-1:0]     o_idx,
    output logic [SIZE_BITS-1:0] o_val
);

    logic                 r_found;
    logic [IDX_W-1:0]     r_idx;
    logic [SIZE_BITS-1:0] r_val;
    logic                 w_fits;
    logic                 w_take;

    // An entry replaces the candidate if it fits and either nothing was found
    // yet or it is strictly better under best or worst fit. Ties keep the
    // earlier entry, and first and next fit keep the first one seen.
    always_comb begin
        w_fits = (i_val >= i_size);
        w_take = i_ctl.valid && w_fits &&
                 (!r_found ||
                  (i_policy == FIT_BEST  && i_val < r_val) ||
                  (i_policy == FIT_WORST && i_val > r_val));
    end

    // Found flag is control state; index and value are payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && !i_ctl.clear) begin
            r_idx <= i_idx;
            r_val <= i_val;
        end
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
    assign o_val   = r_val;

endmodule

[rtl/pfa_checker.sv]
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks of the partition fit allocator's command timing.
// ----------------------------------------------------------------------------
module pfa_checker
    import pfa_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_start,
    input t_in_word  i_req,
    input logic      o_busy,
    input logic      o_done
);

    // A request word always occupies the block.
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_req.mode == MODE_REQUEST) |=> o_busy)
        else $error("request word did not make the block busy");

    // A result only follows an accepted word or a busy period.
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(i_start && !o_busy) || $past(o_busy)))
        else $error("result word without a cause");

    // The result of a request shows once the block has gone idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result word while still busy");

    // Every end of a busy period delivers a result.
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_done)
        else $error("busy period ended without a result word");

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_req   (i_req),
    .o_busy  (o_busy),
    .o_done  (o_done)
);

[verif/partition_fit_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partition_fit_allocator_tb
// Self-checking bench for the partition fit allocator. Load and request words
// are sent through the start/busy handshake with random gaps. A local model of
// the partition table predicts every result word. A checker compares each
// o_done strobe against the oldest prediction, field by field. Directed tests
// cover the placement policies, ties, wrap-around, no fit, zero requests and
// the partition count limits. Random traffic then runs under changing
// settings.
// ----------------------------------------------------------------------------
module partition_fit_allocator_tb;
    import pfa_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASES       = 10;
    localparam int PHASE_WORDS  = 175;
    localparam int MAX_REPORTS  = 50;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    t_in_word              i_req;
    logic                  o_busy;
    logic                  o_done;
    t_out_word             o_res;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // Local copy of the partition table, pointer and settings.
    logic [15:0] free_size [NUM_BLOCKS_DEF];
    logic [2:0]  scan_ptr;
    t_policy     policy_reg;
    logic [3:0]  block_count_reg;

    t_out_word   pending_results[$];
    int          mismatch_count;
    int          stall_cycles;
    int          next_gap;
    bit          start_high;
    bit          no_idle;

    partition_fit_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Expected result of one word; updates the local table as the block would.
    function automatic t_out_word predict_allocation(t_in_word w);
        t_out_word r;
        int        span;
        int        pos;
        int        pick;
        bit        found;
        r     = '0;
        found = 1'b0;
        pick  = 0;
        span  = (block_count_reg > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(block_count_reg);
        if (w.mode == MODE_LOAD) begin
            free_size[w.block_index] = w.size_value;
            scan_ptr       = '0;
            r.block_number = w.block_index;
            r.remaining    = w.size_value;
            return r;
        end
        if (policy_reg == FIT_NEXT) begin
            // Circular scan from the kept pointer, at most one full turn.
            pos = (scan_ptr < span) ? int'(scan_ptr) : 0;
            for (int i = 0; i < span && !found; i++) begin
                if (free_size[pos] >= w.size_value) begin
                    found = 1'b1;
                    pick  = pos;
                end else begin
                    pos = (pos + 1) % span;
                end
            end
            if (found) scan_ptr = pick[2:0];
        end else begin
            // Linear scan; ties keep the lowest index.
            for (int i = 0; i < span && !(found && policy_reg == FIT_FIRST); i++) begin
                if (free_size[i] >= w.size_value) begin
                    if (!found) begin
                        found = 1'b1;
                        pick  = i;
                    end else if (policy_reg == FIT_BEST && free_size[i] < free_size[pick]) begin
                        pick = i;
                    end else if (policy_reg == FIT_WORST && free_size[i] > free_size[pick]) begin
                        pick = i;
                    end
                end
            end
        end
        if (found) begin
            free_size[pick] = free_size[pick] - w.size_value;
            r.granted       = 1'b1;
            r.block_number  = pick[2:0];
            r.remaining     = free_size[pick];
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Sends one word, keeping start high when the next word follows at once.
    task automatic send_word(logic mode, logic [2:0] idx, logic [15:0] size);
        t_in_word w;
        w = '{mode: mode, block_index: idx, size_value: size};
        if (next_gap > 0) repeat (next_gap) @(posedge i_clk);
        i_start    <= 1'b1;
        i_req      <= w;
        start_high = 1'b1;
        do @(posedge i_clk); while (o_busy);
        pending_results.push_back(predict_allocation(w));
        next_gap = no_idle ? 0 : $urandom_range(0, 16);
        if (next_gap > 0) begin
            i_start    <= 1'b0;
            start_high = 1'b0;
        end
    endtask

    // Lowers start and waits until every expected result word has arrived.
    task automatic wait_idle();
        if (start_high) begin
            i_start    <= 1'b0;
            start_high = 1'b0;
        end
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == CFG_POLICY) policy_reg = t_policy'(data[1:0]);
        else block_count_reg = data;
        @(posedge i_clk);
    endtask

    // Request sizes aimed at exact fits, near misses and the field extremes.
    function automatic logic [15:0] draw_request_size();
        logic [15:0] probe;
        probe = free_size[$urandom_range(0, NUM_BLOCKS_DEF - 1)];
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1, 2:    return probe;
            3:       return probe + 16'd1;
            4:       return 16'hFFFF;
            5, 6:    return 16'($urandom_range(0, 255));
            7:       return 16'($urandom_range(0, probe));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Every partition gets a defined size, extremes included.
    task automatic test_load_extremes();
        send_word(MODE_LOAD, 3'd0, 16'h0000);
        send_word(MODE_LOAD, 3'd1, 16'hFFFF);
        send_word(MODE_LOAD, 3'd2, 16'd100);
        send_word(MODE_LOAD, 3'd3, 16'd40);
        send_word(MODE_LOAD, 3'd4, 16'd100);
        send_word(MODE_LOAD, 3'd5, 16'd40);
        send_word(MODE_LOAD, 3'd6, 16'd7);
        send_word(MODE_LOAD, 3'd7, 16'h8000);
    endtask

    // First, best and worst fit on a table with tied sizes.
    task automatic test_linear_policies();
        send_word(MODE_REQUEST, 3'd5, 16'd40);
        wait_idle();
        write_register(CFG_POLICY, 4'(FIT_BEST));
        send_word(MODE_REQUEST, 3'd0, 16'd40);
        wait_idle();
        write_register(CFG_POLICY, {2'b11, FIT_WORST});
        send_word(MODE_REQUEST, 3'd7, 16'd40);
    endtask

    // Next fit: pointer kept on the pick, wrap past the top, no fit after a
    // full turn, pointer above a lowered count, and rewind by a load.
    task automatic test_next_fit();
        wait_idle();
        write_register(CFG_POLICY, 4'(FIT_NEXT));
        send_word(MODE_REQUEST, 3'd0, 16'd50);
        send_word(MODE_REQUEST, 3'd0, 16'd65000);
        send_word(MODE_REQUEST, 3'd0, 16'd30000);
        send_word(MODE_REQUEST, 3'd0, 16'd1000);
        send_word(MODE_REQUEST, 3'd0, 16'd3000);
        wait_idle();
        write_register(CFG_COUNT, 4'd2);
        send_word(MODE_REQUEST, 3'd0, 16'd1);
        send_word(MODE_LOAD, 3'd0, 16'd5);
        send_word(MODE_REQUEST, 3'd0, 16'd1);
    endtask

    // Zero and oversized counts, a zero request and a request that never fits.
    task automatic test_count_limits();
        wait_idle();
        write_register(CFG_COUNT, 4'd0);
        send_word(MODE_REQUEST, 3'd0, 16'd0);
        wait_idle();
        write_register(CFG_COUNT, 4'd15);
        send_word(MODE_REQUEST, 3'd0, 16'd0);
        send_word(MODE_REQUEST, 3'd0, 16'hFFFF);
        wait_idle();
        write_register(CFG_COUNT, COUNT_RESET);
        write_register(CFG_POLICY, 4'(FIT_FIRST));
    endtask

    // Mixed loads and requests under a new policy and count in each phase.
    task automatic test_random_traffic();
        logic [3:0] counts [PHASES];
        counts = '{4'd8, 4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd9, 4'd2};
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            write_register(CFG_POLICY, {2'($urandom_range(0, 3)), 2'(p % 4)});
            write_register(CFG_COUNT, counts[p]);
            no_idle = (p % 3 == 1);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 7))
                        0:       send_word(MODE_LOAD, 3'($urandom_range(0, 7)), 16'h0000);
                        1:       send_word(MODE_LOAD, 3'($urandom_range(0, 7)), 16'hFFFF);
                        default: send_word(MODE_LOAD, 3'($urandom_range(0, 7)),
                                           16'($urandom_range(0, 65535)));
                    endcase
                end else begin
                    send_word(MODE_REQUEST, 3'($urandom_range(0, 7)), draw_request_size());
                end
            end
        end
    endtask

    // Compares each result word with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_out_word exp_w;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result g=%0b n=%0d r=%0d",
                                o_res.granted, o_res.block_number, o_res.remaining));
            end else begin
                exp_w = pending_results.pop_front();
                if (o_res.granted !== exp_w.granted)
                    report_mismatch($sformatf("granted %0b, expected %0b",
                                    o_res.granted, exp_w.granted));
                if (o_res.block_number !== exp_w.block_number)
                    report_mismatch($sformatf("block_number %0d, expected %0d",
                                    o_res.block_number, exp_w.block_number));
                if (o_res.remaining !== exp_w.remaining)
                    report_mismatch($sformatf("remaining %0d, expected %0d",
                                    o_res.remaining, exp_w.remaining));
            end
        end
    end

    // Ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_req       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= '0;
        i_cfg_wdata <= '0;
        mismatch_count  = 0;
        stall_cycles    = 0;
        next_gap        = 0;
        start_high      = 1'b0;
        no_idle         = 1'b0;
        scan_ptr        = '0;
        policy_reg      = FIT_FIRST;
        block_count_reg = COUNT_RESET;
        foreach (free_size[i]) free_size[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_load_extremes();
        test_linear_policies();
        test_next_fit();
        test_count_limits();
        test_random_traffic();
        wait_idle();

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[partition_fit_allocator.f]
rtl/pfa_pkg.sv
rtl/pfa_pick.sv
rtl/partition_fit_allocator.sv
rtl/pfa_checker.sv
verif/partition_fit_allocator_tb.sv
